### rtl/core/frp_pkg.sv
package frp_pkg;

  // field widths
  localparam int unsigned RateW = 32;
  localparam int unsigned HalfW = 16;

  // shared divider sizing: dividend covers 2*x*65535 + y, divisor covers 2*y
  localparam int unsigned DvdW  = 50;
  localparam int unsigned DvsW  = 33;
  localparam int unsigned StepW = 6;

  // zero padding that lifts a 32-bit term to the dividend width
  localparam int unsigned PadW  = DvdW - RateW;

  // step counts per operation
  localparam logic [StepW-1:0] StepsWord  = StepW'(RateW);
  localparam logic [StepW-1:0] StepsScale = StepW'(DvdW);

  localparam logic [HalfW-1:0] HalfMax = {HalfW{1'b1}};

  // divider request
  typedef struct packed {
    logic                   go;
    logic [StepW-1:0]       steps;
    logic [DvdW-1:0]        dividend;
    logic [DvsW-1:0]        divisor;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic                   done;
    logic [DvdW-1:0]        quotient;
    logic [DvsW-1:0]        remainder;
  } div_rsp_t;

endpackage

### rtl/core/frame_rate_ratio_packer_unit.sv
// sequence: a zero numerator, or two terms that both fit 16 bits, is packed straight from
// the check state; otherwise euclid remainder steps on the divider find the gcd, two divisions
// take it out of both terms and, if they still exceed 16 bits, a rounded scaling follows
// throughput: one request at a time, set by the shared radix-2 divider, busy high meanwhile
// results are strobed for one cycle on valid_o; the receiver cannot stall
// reset clears the sequencer, the divider control and the result strobe
module frame_rate_ratio_packer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [frp_pkg::RateW-1:0]   rate_numerator_i,
  input  logic [frp_pkg::RateW-1:0]   rate_denominator_i,
  output logic                        valid_o,
  output logic [frp_pkg::RateW-1:0]   packed_rate_o,
  output logic                        precision_lost_o
);

  typedef enum logic [3:0] {
    StIdle,
    StCheck,
    StGcd,
    StGcdWait,
    StDivNWait,
    StDivDWait,
    StFit,
    StScale,
    StScaleWait
  } state_e;

  state_e                      state_q;
  logic [frp_pkg::RateW-1:0]   n_q;
  logic [frp_pkg::RateW-1:0]   d_q;
  logic [frp_pkg::RateW-1:0]   a_q;
  logic [frp_pkg::RateW-1:0]   b_q;
  logic                        swap_q;
  logic                        valid_q;
  logic [frp_pkg::RateW-1:0]   packed_q;
  logic                        lost_q;
  frp_pkg::div_req_t           div_req_q;
  frp_pkg::div_rsp_t           div_rsp;

  logic [frp_pkg::DvdW-1:0]    x_ext;
  logic [frp_pkg::DvdW-1:0]    y_ext;
  logic [frp_pkg::DvdW-1:0]    scale_num;
  logic [frp_pkg::RateW-1:0]   d_one;
  logic [frp_pkg::RateW-1:0]   quo_word;
  logic [frp_pkg::HalfW-1:0]   q_half;

  // shared divider
  frp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // scaling numerator 2*x*65535 + y as shifts and adds
  always_comb begin
    x_ext     = {{frp_pkg::PadW{1'b0}}, a_q};
    y_ext     = {{frp_pkg::PadW{1'b0}}, b_q};
    scale_num = (x_ext << (frp_pkg::HalfW + 1)) - (x_ext << 1) + y_ext;
    d_one     = (d_q == '0) ? frp_pkg::RateW'(1) : d_q;
    quo_word  = div_rsp.quotient[frp_pkg::RateW-1:0];
    q_half    = div_rsp.quotient[frp_pkg::HalfW-1:0];
  end

  // sequencer with registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= 1'b0;
      div_req_q.go <= 1'b0;
    end else begin
      valid_q      <= 1'b0;
      div_req_q.go <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            n_q     <= rate_numerator_i;
            d_q     <= rate_denominator_i;
            state_q <= StCheck;
          end
        end
        StCheck: begin
          d_q <= d_one;
          if (n_q == '0) begin
            packed_q <= '0;
            lost_q   <= 1'b0;
            valid_q  <= 1'b1;
            state_q  <= StIdle;
          end else if (((n_q | d_one) >> frp_pkg::HalfW) == '0) begin
            packed_q <= {d_one[frp_pkg::HalfW-1:0], n_q[frp_pkg::HalfW-1:0]};
            lost_q   <= 1'b0;
            valid_q  <= 1'b1;
            state_q  <= StIdle;
          end else begin
            a_q     <= n_q;
            b_q     <= d_one;
            state_q <= StGcd;
          end
        end
        StGcd: begin
          if (b_q == '0) begin
            // a holds the gcd
            if (a_q > frp_pkg::RateW'(1)) begin
              div_req_q.go       <= 1'b1;
              div_req_q.steps    <= frp_pkg::StepsWord;
              div_req_q.dividend <= {n_q, {frp_pkg::PadW{1'b0}}};
              div_req_q.divisor  <= frp_pkg::DvsW'(a_q);
              state_q            <= StDivNWait;
            end else begin
              state_q <= StFit;
            end
          end else begin
            div_req_q.go       <= 1'b1;
            div_req_q.steps    <= frp_pkg::StepsWord;
            div_req_q.dividend <= {a_q, {frp_pkg::PadW{1'b0}}};
            div_req_q.divisor  <= frp_pkg::DvsW'(b_q);
            state_q            <= StGcdWait;
          end
        end
        StGcdWait: begin
          if (div_rsp.done) begin
            a_q     <= b_q;
            b_q     <= div_rsp.remainder[frp_pkg::RateW-1:0];
            state_q <= StGcd;
          end
        end
        StDivNWait: begin
          if (div_rsp.done) begin
            n_q                <= quo_word;
            div_req_q.go       <= 1'b1;
            div_req_q.steps    <= frp_pkg::StepsWord;
            div_req_q.dividend <= {d_q, {frp_pkg::PadW{1'b0}}};
            div_req_q.divisor  <= frp_pkg::DvsW'(a_q);
            state_q            <= StDivDWait;
          end
        end
        StDivDWait: begin
          if (div_rsp.done) begin
            d_q     <= quo_word;
            state_q <= StFit;
          end
        end
        StFit: begin
          if (((n_q | d_q) >> frp_pkg::HalfW) == '0) begin
            packed_q <= {d_q[frp_pkg::HalfW-1:0], n_q[frp_pkg::HalfW-1:0]};
            lost_q   <= 1'b0;
            valid_q  <= 1'b1;
            state_q  <= StIdle;
          end else begin
            // smaller term scaled against the larger one
            swap_q  <= (n_q > d_q);
            a_q     <= (n_q > d_q) ? d_q : n_q;
            b_q     <= (n_q > d_q) ? n_q : d_q;
            state_q <= StScale;
          end
        end
        StScale: begin
          div_req_q.go       <= 1'b1;
          div_req_q.steps    <= frp_pkg::StepsScale;
          div_req_q.dividend <= scale_num;
          div_req_q.divisor  <= {b_q, 1'b0};
          state_q            <= StScaleWait;
        end
        StScaleWait: begin
          if (div_rsp.done) begin
            if (swap_q) begin
              packed_q <= {(q_half == '0) ? frp_pkg::HalfW'(1) : q_half, frp_pkg::HalfMax};
            end else begin
              packed_q <= {frp_pkg::HalfMax, q_half};
            end
            lost_q  <= 1'b1;
            valid_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy             = (state_q != StIdle);
  assign valid_o          = valid_q;
  assign packed_rate_o    = packed_q;
  assign precision_lost_o = lost_q;

endmodule

### rtl/core/frp_div.sv
module frp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frp_pkg::div_req_t req_i,
  output frp_pkg::div_rsp_t rsp_o
);

  logic [frp_pkg::DvsW-1:0]  rem_q;
  logic [frp_pkg::DvdW-1:0]  quo_q;
  logic [frp_pkg::DvsW-1:0]  dvs_q;
  logic [frp_pkg::StepW-1:0] cnt_q;
  logic                      active_q;
  logic                      done_q;

  logic [frp_pkg::DvsW:0]    trial;
  logic                      fits;
  logic [frp_pkg::DvsW:0]    diff;

  // one restoring step: bring in next dividend bit, trial subtract
  always_comb begin
    trial = {rem_q, quo_q[frp_pkg::DvdW-1]};
    fits  = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
  end

  // control: load, count steps, pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        active_q <= 1'b1;
        cnt_q    <= req_i.steps;
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == frp_pkg::StepW'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (active_q) begin
      rem_q <= fits ? diff[frp_pkg::DvsW-1:0] : trial[frp_pkg::DvsW-1:0];
      quo_q <= {quo_q[frp_pkg::DvdW-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
